@@ sv/coospmv_pkg.sv @@
// Shared types, constants and fixed-point helpers for the COO sparse
// matrix-vector multiply block. No dependencies; every other file imports it.
package coospmv_pkg;

    localparam int DEFAULT_MAX_DIM     = 4096;
    localparam int DEFAULT_QUEUE_DEPTH = 2;

    localparam int IDX_W      = 12;
    localparam int CNT_W      = 13;
    localparam int DATA_W     = 32;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    localparam logic signed [DATA_W-1:0] Q_ONE = 32'sd65536;

    // Request operation codes.
    localparam logic [1:0] OP_LOAD_X  = 2'd0;
    localparam logic [1:0] OP_LOAD_Y  = 2'd1;
    localparam logic [1:0] OP_TRIPLET = 2'd2;
    localparam logic [1:0] OP_READ_Y  = 2'd3;

    // Configuration register indexes (word address).
    localparam logic [2:0] REG_ROW_COUNT      = 3'd0;
    localparam logic [2:0] REG_COLUMN_COUNT   = 3'd1;
    localparam logic [2:0] REG_ALPHA_GAIN     = 3'd2;
    localparam logic [2:0] REG_BETA_GAIN      = 3'd3;
    localparam logic [2:0] REG_TRANSPOSE_MODE = 3'd4;

    typedef struct packed {
        logic [1:0]              op;
        logic [IDX_W-1:0]        vec_index;
        logic [IDX_W-1:0]        row_index;
        logic [IDX_W-1:0]        col_index;
        logic signed [DATA_W-1:0] data_value;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        logic                     status;
    } t_out_item;

    typedef struct packed {
        logic [CNT_W-1:0]         row_count;
        logic [CNT_W-1:0]         column_count;
        logic signed [DATA_W-1:0] alpha_gain;
        logic signed [DATA_W-1:0] beta_gain;
        logic                     transpose_mode;
    } t_cfg;

    // What the back end has to do with a classified request.
    typedef enum logic [2:0] {
        K_NONE,
        K_LDX,
        K_LDY,
        K_LDY_SCALE,
        K_MAC,
        K_READ
    } t_kind;

    typedef struct packed {
        t_kind                    kind;
        logic                     status;
        logic [IDX_W-1:0]         src;
        logic [IDX_W-1:0]         dst;
        logic signed [DATA_W-1:0] data;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WAIT,
        ST_MUL1,
        ST_SAT1,
        ST_MUL2,
        ST_SAT2,
        ST_ACC,
        ST_DONE
    } t_state;

    // Q16.16 rescale of a full product: divide by 2^16 truncating toward zero,
    // then saturate to 32 bits.
    function automatic logic signed [DATA_W-1:0] q_scale(input logic signed [63:0] p);
        logic signed [47:0] q;
        q = $signed(p[63:16]);
        if (p[63] && (p[15:0] != 16'd0)) begin
            q = q + 48'sd1;
        end
        if (q > 48'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (q < -48'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return q[31:0];
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_add(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        logic signed [DATA_W:0] s;
        s = 33'(a) + 33'(b);
        if (s[DATA_W] != s[DATA_W-1]) begin
            return s[DATA_W] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        return s[DATA_W-1:0];
    endfunction

endpackage

@@ sv/coospmv_front.sv @@
// Front end: takes requests, checks indices against the configured lengths and
// turns each into a command for the back end. Depends on coospmv_pkg.
module coospmv_front #(
    parameter int MAX_DIM = coospmv_pkg::DEFAULT_MAX_DIM
) (
    input  coospmv_pkg::t_cfg     i_cfg,
    input  logic                  i_in_valid,
    input  coospmv_pkg::t_in_item i_in_data,
    output logic                  o_in_stall,
    input  logic                  i_q_full,
    output logic                  o_push,
    output coospmv_pkg::t_cmd     o_cmd
);
    import coospmv_pkg::*;

    localparam int LW = $clog2(MAX_DIM + 1);
    localparam int CW = (LW > CNT_W) ? LW : CNT_W;

    logic [CW-1:0] w_rows;
    logic [CW-1:0] w_cols;
    logic [CW-1:0] w_xlen;
    logic [CW-1:0] w_ylen;
    logic [CW-1:0] w_vi;
    logic [CW-1:0] w_ri;
    logic [CW-1:0] w_ci;

    assign w_rows = (CW'(i_cfg.row_count) > CW'(MAX_DIM)) ? CW'(MAX_DIM)
                                                         : CW'(i_cfg.row_count);
    assign w_cols = (CW'(i_cfg.column_count) > CW'(MAX_DIM)) ? CW'(MAX_DIM)
                                                            : CW'(i_cfg.column_count);
    assign w_xlen = i_cfg.transpose_mode ? w_rows : w_cols;
    assign w_ylen = i_cfg.transpose_mode ? w_cols : w_rows;
    assign w_vi   = CW'(i_in_data.vec_index);
    assign w_ri   = CW'(i_in_data.row_index);
    assign w_ci   = CW'(i_in_data.col_index);

    always_comb begin
        o_cmd.kind   = K_NONE;
        o_cmd.status = 1'b0;
        o_cmd.src    = i_in_data.vec_index;
        o_cmd.dst    = i_in_data.vec_index;
        o_cmd.data   = i_in_data.data_value;
        case (i_in_data.op)
            OP_LOAD_X: begin
                if (w_vi < w_xlen) begin
                    o_cmd.kind = K_LDX;
                end else begin
                    o_cmd.status = 1'b1;
                end
            end
            OP_LOAD_Y: begin
                if (w_vi < w_ylen) begin
                    // Beta of zero and of one need no multiply.
                    if (i_cfg.beta_gain == '0) begin
                        o_cmd.kind = K_LDY;
                        o_cmd.data = '0;
                    end else if (i_cfg.beta_gain == Q_ONE) begin
                        o_cmd.kind = K_LDY;
                    end else begin
                        o_cmd.kind = K_LDY_SCALE;
                    end
                end else begin
                    o_cmd.status = 1'b1;
                end
            end
            OP_TRIPLET: begin
                o_cmd.src = i_cfg.transpose_mode ? i_in_data.row_index
                                                 : i_in_data.col_index;
                o_cmd.dst = i_cfg.transpose_mode ? i_in_data.col_index
                                                 : i_in_data.row_index;
                if ((w_ri < w_rows) && (w_ci < w_cols)) begin
                    if (i_cfg.alpha_gain != '0) begin
                        o_cmd.kind = K_MAC;
                    end
                end else begin
                    o_cmd.status = 1'b1;
                end
            end
            OP_READ_Y: begin
                if (w_vi < w_ylen) begin
                    o_cmd.kind = K_READ;
                end else begin
                    o_cmd.status = 1'b1;
                end
            end
            default: begin
                o_cmd.kind = K_NONE;
            end
        endcase
    end

    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

endmodule

@@ sv/coospmv_fifo.sv @@
// Short command queue between the front end and the back end.
// Depends on coospmv_pkg for the command type.
module coospmv_fifo #(
    parameter int DEPTH = coospmv_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  coospmv_pkg::t_cmd i_data,
    output logic              o_full,
    input  logic              i_pop,
    output coospmv_pkg::t_cmd o_data,
    output logic              o_empty
);
    import coospmv_pkg::*;

    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    t_cmd            r_mem [DEPTH];
    logic [PW-1:0]   r_wptr;
    logic [PW-1:0]   r_rptr;
    logic [CNTW-1:0] r_count;
    logic [PW-1:0]   n_wptr;
    logic [PW-1:0]   n_rptr;
    logic [CNTW-1:0] n_count;

    assign o_full  = (r_count == CNTW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

@@ sv/coospmv_back.sv @@
// Back end: x and y vector memories, one shared multiplier with Q16.16
// rescale and the saturating accumulate, plus the result register.
// Depends on coospmv_pkg.
module coospmv_back #(
    parameter int MAX_DIM = coospmv_pkg::DEFAULT_MAX_DIM
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  coospmv_pkg::t_cfg      i_cfg,
    input  logic                   i_q_empty,
    input  coospmv_pkg::t_cmd      i_q_data,
    output logic                   o_pop,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output coospmv_pkg::t_out_item o_out_data
);
    import coospmv_pkg::*;

    localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    typedef struct packed {
        logic pop;
        logic out_load;
        logic x_we;
        logic y_we;
    } t_back_ctl;

    t_state                   r_state;
    t_state                   n_state;
    t_back_ctl                w_ctl;
    t_cmd                     r_cmd;
    logic signed [63:0]       r_prod;
    logic signed [63:0]       w_prod;
    logic signed [DATA_W-1:0] w_op_a;
    logic signed [DATA_W-1:0] w_op_b;
    logic signed [DATA_W-1:0] r_val;
    logic signed [DATA_W-1:0] n_val;
    logic signed [DATA_W-1:0] r_x_rd;
    logic signed [DATA_W-1:0] r_y_rd;
    logic signed [DATA_W-1:0] w_y_wdata;
    logic [AW-1:0]            w_x_addr;
    logic [AW-1:0]            w_y_addr;
    logic                     w_out_free;
    logic                     r_out_valid;
    t_out_item                r_out_data;

    logic signed [DATA_W-1:0] x_mem [MAX_DIM];
    logic signed [DATA_W-1:0] y_mem [MAX_DIM];

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_x_addr   = AW'(r_cmd.src);
    assign w_y_addr   = AW'(r_cmd.dst);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    case (i_q_data.kind)
                        K_READ:             n_state = ST_WAIT;
                        K_LDY_SCALE, K_MAC: n_state = ST_MUL1;
                        default:            n_state = ST_DONE;
                    endcase
                end
            end
            ST_WAIT: n_state = ST_DONE;
            ST_MUL1: n_state = ST_SAT1;
            ST_SAT1: n_state = (r_cmd.kind == K_MAC) ? ST_MUL2 : ST_DONE;
            ST_MUL2: n_state = ST_SAT2;
            ST_SAT2: n_state = ST_ACC;
            ST_ACC:  n_state = ST_DONE;
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_ctl.pop      = (r_state == ST_IDLE) && !i_q_empty;
        w_ctl.out_load = (r_state == ST_DONE) && w_out_free;
        w_ctl.x_we     = w_ctl.out_load && (r_cmd.kind == K_LDX);
        w_ctl.y_we     = w_ctl.out_load && (r_cmd.kind inside {K_LDY, K_LDY_SCALE, K_MAC});
    end

    assign o_pop = w_ctl.pop;

    // The one multiplier serves beta*data, alpha*data and then (alpha*data)*x.
    always_comb begin
        if (r_state == ST_MUL2) begin
            w_op_a = r_val;
            w_op_b = r_x_rd;
        end else begin
            w_op_a = (r_cmd.kind == K_LDY_SCALE) ? i_cfg.beta_gain : i_cfg.alpha_gain;
            w_op_b = r_cmd.data;
        end
    end

    assign w_prod = w_op_a * w_op_b;

    always_comb begin
        n_val = r_val;
        case (r_state)
            ST_SAT1, ST_SAT2: n_val = q_scale(r_prod);
            ST_ACC:           n_val = sat_add(r_y_rd, r_val);
            default:          n_val = r_val;
        endcase
    end

    assign w_y_wdata = (r_cmd.kind == K_LDY) ? r_cmd.data : r_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_ctl.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.pop) begin
            r_cmd <= i_q_data;
        end
        r_prod <= w_prod;
        r_val  <= n_val;
        if (w_ctl.out_load) begin
            r_out_data.read_value <= (r_cmd.kind == K_READ) ? r_y_rd : '0;
            r_out_data.status     <= r_cmd.status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.x_we) begin
            x_mem[w_x_addr] <= r_cmd.data;
        end
        r_x_rd <= x_mem[w_x_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.y_we) begin
            y_mem[w_y_addr] <= w_y_wdata;
        end
        r_y_rd <= y_mem[w_y_addr];
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_x_write_only_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.x_we |-> (r_cmd.kind == K_LDX) && !r_cmd.status)
        else $error("x memory written by a request that is not an x load");

    a_y_write_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.y_we |-> (r_cmd.kind == K_LDY || r_cmd.kind == K_LDY_SCALE ||
                        r_cmd.kind == K_MAC) && !r_cmd.status)
        else $error("y memory written by a request that does not update y");

    a_mac_timing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL1) && (r_cmd.kind == K_MAC) |=> ##3 (r_state == ST_ACC))
        else $error("triplet did not reach the accumulate step on time");

    a_pop_needs_idle_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.pop |=> (r_state != ST_IDLE))
        else $error("back end stayed idle after taking a command");

endmodule

@@ sv/coo_sparse_matrix_vector_multiply.sv @@
// COO sparse matrix-vector multiply, y = alpha*A*x + beta*y, Q16.16.
// X loads, unscaled y loads, rejects and skipped triplets go straight to the result
// register; y reads wait in ST_WAIT, scaled y loads pass MUL1 and SAT1, triplets MUL1,
// SAT1, MUL2, SAT2 and ACC. One request at a time runs through the shared multiplier,
// none popped until the last result loads; a two-entry queue decouples input.
// Synchronous reset sets configuration, queue and control state to their defaults; x and y hold no reset value.
module coo_sparse_matrix_vector_multiply #(
    parameter int MAX_DIM     = coospmv_pkg::DEFAULT_MAX_DIM,
    parameter int QUEUE_DEPTH = coospmv_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  coospmv_pkg::t_in_item               i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output coospmv_pkg::t_out_item              o_out_data,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [coospmv_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [coospmv_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [coospmv_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                pready
);
    import coospmv_pkg::*;

    t_cfg       r_cfg;
    logic [2:0] w_reg_idx;
    logic       w_cfg_we;
    logic       w_push;
    logic       w_pop;
    logic       w_q_full;
    logic       w_q_empty;
    t_cmd       w_front_cmd;
    t_cmd       w_q_cmd;

    assign pready    = 1'b1;
    assign w_reg_idx = paddr[4:2];
    assign w_cfg_we  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.row_count      <= '0;
            r_cfg.column_count   <= '0;
            r_cfg.alpha_gain     <= Q_ONE;
            r_cfg.beta_gain      <= '0;
            r_cfg.transpose_mode <= 1'b0;
        end else if (w_cfg_we) begin
            case (w_reg_idx)
                REG_ROW_COUNT:      r_cfg.row_count      <= pwdata[CNT_W-1:0];
                REG_COLUMN_COUNT:   r_cfg.column_count   <= pwdata[CNT_W-1:0];
                REG_ALPHA_GAIN:     r_cfg.alpha_gain     <= pwdata;
                REG_BETA_GAIN:      r_cfg.beta_gain      <= pwdata;
                REG_TRANSPOSE_MODE: r_cfg.transpose_mode <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            REG_ROW_COUNT:      prdata = APB_DATA_W'(r_cfg.row_count);
            REG_COLUMN_COUNT:   prdata = APB_DATA_W'(r_cfg.column_count);
            REG_ALPHA_GAIN:     prdata = r_cfg.alpha_gain;
            REG_BETA_GAIN:      prdata = r_cfg.beta_gain;
            REG_TRANSPOSE_MODE: prdata = APB_DATA_W'(r_cfg.transpose_mode);
            default:            prdata = '0;
        endcase
    end

    coospmv_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .i_cfg      (r_cfg),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .i_q_full   (w_q_full),
        .o_push     (w_push),
        .o_cmd      (w_front_cmd)
    );

    coospmv_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_front_cmd),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_data  (w_q_cmd),
        .o_empty (w_q_empty)
    );

    coospmv_back #(
        .MAX_DIM (MAX_DIM)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_empty   (w_q_empty),
        .i_q_data    (w_q_cmd),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// Testbench for coo_sparse_matrix_vector_multiply. Directed and random requests are
// checked, one result at a time, against an in-bench model of the Q16.16 x and y stores.
// Depends on coospmv_pkg and the block's RTL only.
module tb;
    import coospmv_pkg::*;

    localparam int     CYCLE_LIMIT = 300000;
    localparam longint WORD_MAX    = 64'sd2147483647;
    localparam longint WORD_MIN    = -64'sd2147483648;

    class spmv_scoreboard;
        logic [CNT_W-1:0]         rows_cfg  = '0;
        logic [CNT_W-1:0]         cols_cfg  = '0;
        logic signed [DATA_W-1:0] alpha     = Q_ONE;
        logic signed [DATA_W-1:0] beta      = '0;
        logic                     transpose = 1'b0;
        logic signed [DATA_W-1:0] x_mem [DEFAULT_MAX_DIM];
        logic signed [DATA_W-1:0] y_mem [DEFAULT_MAX_DIM];
        t_out_item                owed_replies [$];
        int unsigned              mismatch_count = 0;

        function logic signed [DATA_W-1:0] clamp_word(input longint v);
            if (v > WORD_MAX) return 32'sh7FFF_FFFF;
            if (v < WORD_MIN) return 32'sh8000_0000;
            return 32'(v);
        endfunction

        // Signed division truncates toward zero, which is the rounding the block uses.
        function logic signed [DATA_W-1:0] scaled_product(input logic signed [DATA_W-1:0] a,
                                                         input logic signed [DATA_W-1:0] b);
            return clamp_word((longint'(a) * longint'(b)) / 64'sd65536);
        endfunction

        function void write_reg(input logic [2:0] idx, input logic [APB_DATA_W-1:0] value);
            case (idx)
                REG_ROW_COUNT:      rows_cfg  = value[CNT_W-1:0];
                REG_COLUMN_COUNT:   cols_cfg  = value[CNT_W-1:0];
                REG_ALPHA_GAIN:     alpha     = value;
                REG_BETA_GAIN:      beta      = value;
                REG_TRANSPOSE_MODE: transpose = value[0];
                default: ;
            endcase
        endfunction

        function void apply_request(input t_in_item r);
            t_out_item                reply;
            int                       rows, cols, x_len, y_len, src, dst;
            logic signed [DATA_W-1:0] term;
            rows  = (rows_cfg > DEFAULT_MAX_DIM) ? DEFAULT_MAX_DIM : int'(rows_cfg);
            cols  = (cols_cfg > DEFAULT_MAX_DIM) ? DEFAULT_MAX_DIM : int'(cols_cfg);
            x_len = transpose ? rows : cols;
            y_len = transpose ? cols : rows;
            reply.read_value = '0;
            reply.status     = 1'b0;
            case (r.op)
                OP_LOAD_X: begin
                    if (r.vec_index < x_len) begin
                        x_mem[r.vec_index] = r.data_value;
                    end else begin
                        reply.status = 1'b1;
                    end
                end
                OP_LOAD_Y: begin
                    if (r.vec_index < y_len) begin
                        if (beta == 0) begin
                            y_mem[r.vec_index] = '0;
                        end else if (beta == Q_ONE) begin
                            y_mem[r.vec_index] = r.data_value;
                        end else begin
                            y_mem[r.vec_index] = scaled_product(beta, r.data_value);
                        end
                    end else begin
                        reply.status = 1'b1;
                    end
                end
                OP_TRIPLET: begin
                    if (r.row_index < rows && r.col_index < cols) begin
                        if (alpha != 0) begin
                            src  = transpose ? r.row_index : r.col_index;
                            dst  = transpose ? r.col_index : r.row_index;
                            term = scaled_product(scaled_product(alpha, r.data_value), x_mem[src]);
                            y_mem[dst] = clamp_word(longint'(y_mem[dst]) + longint'(term));
                        end
                    end else begin
                        reply.status = 1'b1;
                    end
                end
                default: begin
                    if (r.vec_index < y_len) begin
                        reply.read_value = y_mem[r.vec_index];
                    end else begin
                        reply.status = 1'b1;
                    end
                end
            endcase
            owed_replies = {owed_replies, reply};
        endfunction

        task report_mismatch(input string what);
            mismatch_count++;
            $display("mismatch at %0t ns: %s", $time, what);
        endtask

        task check_reply(input t_out_item got);
            t_out_item want;
            if (owed_replies.size() == 0) begin
                report_mismatch($sformatf("result with none outstanding: value %h status %b",
                                          got.read_value, got.status));
                return;
            end
            want = owed_replies.pop_front();
            if (got.read_value !== want.read_value) begin
                report_mismatch($sformatf("read_value %h, wanted %h",
                                          got.read_value, want.read_value));
            end
            if (got.status !== want.status) begin
                report_mismatch($sformatf("status %b, wanted %b", got.status, want.status));
            end
        endtask
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  req_valid = 1'b0;
    logic                  req_stall;
    t_in_item              req_data  = '0;
    logic                  res_valid;
    logic                  res_stall = 1'b0;
    t_out_item             res_data;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [APB_ADDR_W-1:0] paddr     = '0;
    logic [APB_DATA_W-1:0] pwdata    = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    spmv_scoreboard        sb;
    int                    cycle_count    = 0;
    int                    send_idle_pct  = 0;
    int                    recv_stall_pct = 0;
    int                    hold_left      = 0;

    // Bench copy of the settings, used to shape stimulus and to track which
    // store entries have been written since reset.
    int                       cfg_rows      = 0;
    int                       cfg_cols      = 0;
    logic signed [DATA_W-1:0] cfg_alpha     = Q_ONE;
    logic                     cfg_transpose = 1'b0;
    bit                       x_loaded [DEFAULT_MAX_DIM];
    bit                       y_loaded [DEFAULT_MAX_DIM];

    int                       forced_rows  [4] = '{4096, 0, 9, 1};
    int                       forced_cols  [4] = '{4096, 6, 0, 4096};
    logic signed [DATA_W-1:0] forced_alpha [5] = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0,
                                                   -Q_ONE, Q_ONE};
    logic signed [DATA_W-1:0] forced_beta  [5] = '{32'sh8000_0000, Q_ONE, 32'sh7FFF_FFFF,
                                                   32'sd0, 32'sh0000_8000};

    coo_sparse_matrix_vector_multiply dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (req_valid),
        .o_in_stall  (req_stall),
        .i_in_data   (req_data),
        .o_out_valid (res_valid),
        .i_out_stall (res_stall),
        .o_out_data  (res_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic signed [DATA_W-1:0] pick_value();
        logic signed [DATA_W-1:0] v;
        case ($urandom_range(11))
            0: v = '0;
            1: v = Q_ONE;
            2: v = -Q_ONE;
            3: v = 32'sh7FFF_FFFF;
            4: v = 32'sh8000_0000;
            5, 6, 7, 8: begin
                v = $urandom_range(32'h0004_0000);
                if ($urandom_range(1) == 1) v = -v;
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic int pick_dim();
        case ($urandom_range(9))
            0: return 0;
            1: return DEFAULT_MAX_DIM;
            2: return 1;
            default: return $urandom_range(2, 40);
        endcase
    endfunction

    // Large vectors are mostly touched near the bottom so that entries get reused.
    function automatic int pick_below(input int n);
        if (n > 24 && $urandom_range(3) != 0) return $urandom_range(23);
        return $urandom_range(n - 1);
    endfunction

    function automatic t_in_item request_of(input logic [1:0] op, input int vi, input int ri,
                                            input int ci, input logic signed [DATA_W-1:0] d);
        t_in_item r;
        r.op         = op;
        r.vec_index  = IDX_W'(vi);
        r.row_index  = IDX_W'(ri);
        r.col_index  = IDX_W'(ci);
        r.data_value = d;
        return r;
    endfunction

    function automatic t_in_item make_request();
        t_in_item r;
        int       x_len, y_len, src, dst, pick;
        logic     tidy;
        x_len        = cfg_transpose ? cfg_rows : cfg_cols;
        y_len        = cfg_transpose ? cfg_cols : cfg_rows;
        r.op         = OP_LOAD_X;
        r.vec_index  = IDX_W'($urandom);
        r.row_index  = IDX_W'($urandom);
        r.col_index  = IDX_W'($urandom);
        r.data_value = pick_value();
        tidy         = ($urandom_range(99) < 85);
        pick         = $urandom_range(99);
        if (pick < 20) begin
            r.op = OP_LOAD_X;
            if (tidy && x_len > 0) r.vec_index = IDX_W'(pick_below(x_len));
        end else if (pick < 40) begin
            r.op = OP_LOAD_Y;
            if (tidy && y_len > 0) r.vec_index = IDX_W'(pick_below(y_len));
        end else if (pick < 80) begin
            r.op = OP_TRIPLET;
            if (tidy && x_len > 0 && y_len > 0) begin
                src         = pick_below(x_len);
                dst         = pick_below(y_len);
                r.row_index = IDX_W'(cfg_transpose ? src : dst);
                r.col_index = IDX_W'(cfg_transpose ? dst : src);
            end
            // An accepted triplet with a non-zero gain reads both stores, so a
            // missing entry is loaded first instead.
            if (r.row_index < cfg_rows && r.col_index < cfg_cols && cfg_alpha != 0) begin
                src = cfg_transpose ? r.row_index : r.col_index;
                dst = cfg_transpose ? r.col_index : r.row_index;
                if (!x_loaded[src]) begin
                    r.op        = OP_LOAD_X;
                    r.vec_index = IDX_W'(src);
                end else if (!y_loaded[dst]) begin
                    r.op        = OP_LOAD_Y;
                    r.vec_index = IDX_W'(dst);
                end
            end
        end else begin
            r.op = OP_READ_Y;
            if (tidy && y_len > 0) r.vec_index = IDX_W'(pick_below(y_len));
            if (r.vec_index < y_len && !y_loaded[r.vec_index]) r.op = OP_LOAD_Y;
        end
        return r;
    endfunction

    // Ends after driving the bus idle so that back-to-back writes never
    // drive the bus twice in the same time step.
    task automatic write_register(input logic [2:0] idx, input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1) @(posedge clk);
        sb.write_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input int rows, input int cols, input logic signed [DATA_W-1:0] alpha,
                             input logic signed [DATA_W-1:0] beta, input logic tr);
        write_register(REG_ROW_COUNT, APB_DATA_W'(rows));
        write_register(REG_COLUMN_COUNT, APB_DATA_W'(cols));
        write_register(REG_ALPHA_GAIN, alpha);
        write_register(REG_BETA_GAIN, beta);
        write_register(REG_TRANSPOSE_MODE, APB_DATA_W'(tr));
        cfg_rows      = rows;
        cfg_cols      = cols;
        cfg_alpha     = alpha;
        cfg_transpose = tr;
    endtask

    task automatic send_request(input t_in_item r);
        int x_len, y_len;
        x_len = cfg_transpose ? cfg_rows : cfg_cols;
        y_len = cfg_transpose ? cfg_cols : cfg_rows;
        if (r.op == OP_LOAD_X && r.vec_index < x_len) x_loaded[r.vec_index] = 1'b1;
        if (r.op == OP_LOAD_Y && r.vec_index < y_len) y_loaded[r.vec_index] = 1'b1;
        while ($urandom_range(99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= r;
        @(posedge clk);
        while (req_stall !== 1'b0) @(posedge clk);
        sb.apply_request(r);
    endtask

    // Called just after an accepted request; drops req_valid and waits until no result is owed.
    task automatic wait_until_drained();
        req_valid <= 1'b0;
        @(posedge clk);
        while (sb.owed_replies.size() != 0) @(posedge clk);
    endtask

    initial begin
        forever begin
            @(posedge clk);
            if (rst_n && res_valid === 1'b1 && !res_stall) sb.check_reply(res_data);
            if (hold_left > 0) begin
                res_stall <= 1'b1;
                hold_left--;
            end else begin
                res_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        int                       rows, cols;
        logic signed [DATA_W-1:0] alpha, beta;
        logic                     tr;
        sb = new;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_idle_pct  = 28;
        recv_stall_pct = 48;

        // Saturating sums, truncation of negative products, range checks, unit beta.
        configure(3, 4, Q_ONE, Q_ONE, 1'b0);
        send_request(request_of(OP_LOAD_X, 0, 0, 0, 32'sh7FFF_FFFF));
        send_request(request_of(OP_LOAD_X, 1, 0, 0, 32'sh8000_0000));
        send_request(request_of(OP_LOAD_X, 2, 0, 0, Q_ONE));
        send_request(request_of(OP_LOAD_X, 3, 0, 0, -Q_ONE));
        send_request(request_of(OP_LOAD_X, 4095, 4095, 4095, 32'sh1234_5678));
        send_request(request_of(OP_LOAD_Y, 0, 0, 0, 32'sh7FFF_FFFF));
        send_request(request_of(OP_LOAD_Y, 1, 0, 0, 32'sh8000_0000));
        send_request(request_of(OP_LOAD_Y, 2, 0, 0, 32'sd0));
        send_request(request_of(OP_LOAD_Y, 3, 0, 0, Q_ONE));
        send_request(request_of(OP_TRIPLET, 0, 0, 0, Q_ONE));
        send_request(request_of(OP_TRIPLET, 0, 1, 1, Q_ONE));
        send_request(request_of(OP_TRIPLET, 0, 2, 2, 32'sh7FFF_FFFF));
        send_request(request_of(OP_TRIPLET, 0, 2, 0, -32'sd1));
        send_request(request_of(OP_TRIPLET, 0, 0, 3, 32'sh8000_0000));
        send_request(request_of(OP_TRIPLET, 0, 3, 1, Q_ONE));
        send_request(request_of(OP_TRIPLET, 0, 0, 4095, Q_ONE));
        send_request(request_of(OP_READ_Y, 0, 0, 0, 32'sd0));
        send_request(request_of(OP_READ_Y, 1, 0, 0, 32'sd0));
        send_request(request_of(OP_READ_Y, 2, 0, 0, 32'sd0));
        send_request(request_of(OP_READ_Y, 3, 0, 0, 32'sd0));
        wait_until_drained();
        repeat (8) @(posedge clk);

        // Transpose with zero gains: y loads store zero and triplets are skipped.
        configure(2, 3, 32'sd0, 32'sd0, 1'b1);
        send_request(request_of(OP_LOAD_Y, 0, 0, 0, 32'sh7FFF_FFFF));
        send_request(request_of(OP_TRIPLET, 0, 0, 0, Q_ONE));
        send_request(request_of(OP_READ_Y, 0, 0, 0, 32'sd0));
        wait_until_drained();
        repeat (8) @(posedge clk);

        // General beta scaling and a saturating product through the transpose path.
        configure(2, 3, -Q_ONE, 32'sh0001_8000, 1'b1);
        send_request(request_of(OP_LOAD_Y, 1, 0, 0, 32'sh8000_0000));
        send_request(request_of(OP_TRIPLET, 0, 1, 1, 32'sh0002_0000));
        send_request(request_of(OP_READ_Y, 1, 0, 0, 32'sd0));
        wait_until_drained();
        repeat (8) @(posedge clk);

        for (int ph = 0; ph < 12; ph++) begin
            send_idle_pct  = (ph < 4) ? 28 : (ph < 8) ? 48 : 0;
            recv_stall_pct = (ph < 4) ? 48 : (ph < 8) ? 28 : 0;
            if (ph < 4) begin
                rows = forced_rows[ph];
                cols = forced_cols[ph];
                tr   = 1'(ph % 2);
            end else begin
                rows = pick_dim();
                cols = pick_dim();
                tr   = 1'($urandom_range(1));
            end
            if (ph < 5) begin
                alpha = forced_alpha[ph];
                beta  = forced_beta[ph];
            end else begin
                alpha = pick_value();
                beta  = pick_value();
            end
            configure(rows, cols, alpha, beta, tr);
            for (int n = 0; n < 75; n++) begin
                if (ph == 9 && n == 40) wait_until_drained();
                // A long hold-off on the result side lets the block back up into its input.
                if (ph == 10 && n == 15) hold_left = 160;
                send_request(make_request());
            end
            wait_until_drained();
            repeat (8) @(posedge clk);
        end

        wait_until_drained();
        repeat (16) @(posedge clk);
        if (sb.mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/coospmv_pkg.sv
sv/coospmv_front.sv
sv/coospmv_fifo.sv
sv/coospmv_back.sv
sv/coo_sparse_matrix_vector_multiply.sv
bench/tb.sv
